FILE: design/exp_golomb_bit_writer_defines.svh
// ----------------------------------------------------------------------------
// Exp-Golomb bit writer assertion macros
// Shared property macros for the concurrent checks in the bit packer.
// ----------------------------------------------------------------------------
`ifndef EXP_GOLOMB_BIT_WRITER_DEFINES_SVH
`define EXP_GOLOMB_BIT_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EGBW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EGBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/egbw_pkg.sv
// ----------------------------------------------------------------------------
// Exp-Golomb bit writer package
// Operation codes, limits, sequencer states, the packer load word and a helper.
// ----------------------------------------------------------------------------
package egbw_pkg;

    localparam logic [2:0] FUNC_FIXED = 3'd0;
    localparam logic [2:0] FUNC_UE    = 3'd1;
    localparam logic [2:0] FUNC_SE    = 3'd2;
    localparam logic [2:0] FUNC_SCALE = 3'd3;
    localparam logic [2:0] FUNC_STOP  = 3'd4;

    localparam logic [7:0] SCALE_RESET    = 8'd8;
    localparam logic [5:0] MAX_FIXED_BITS = 6'd32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_SIZE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [31:0] val;
        logic [5:0]  len;
        logic        flush;
    } t_pack_load;

    function automatic logic [4:0] f_msb_len(input logic [15:0] v);
        logic [4:0] len;
        len = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                len = 5'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

FILE: design/egbw_code.sv
// ----------------------------------------------------------------------------
// Exp-Golomb code mapper
// Saturates the code value and maps ue, se and scaling deltas to codeNum + 1.
// ----------------------------------------------------------------------------
module egbw_code
    import egbw_pkg::*;
(
    input  logic [2:0]         i_func,
    input  logic signed [16:0] i_coded_value,
    input  logic [7:0]         i_scale_value,
    input  logic               i_new_list,
    input  logic [7:0]         i_prev_scale,
    output logic [15:0]        o_v
);

    logic [15:0]        ue_sat;
    logic [7:0]         base;
    logic [7:0]         diff;
    logic signed [16:0] s;
    logic signed [16:0] neg;

    always_comb begin
        if (i_coded_value < 17'sd0) begin
            ue_sat = 16'd0;
        end else if (i_coded_value > 17'sd65534) begin
            ue_sat = 16'd65534;
        end else begin
            ue_sat = i_coded_value[15:0];
        end

        base = i_new_list ? SCALE_RESET : i_prev_scale;
        diff = i_scale_value - base;

        if (i_func == FUNC_SCALE) begin
            s = {{9{diff[7]}}, diff};
        end else if (i_coded_value > 17'sd32767) begin
            s = 17'sd32767;
        end else if (i_coded_value < -17'sd32767) begin
            s = -17'sd32767;
        end else begin
            s = i_coded_value;
        end
        neg = 17'sd0 - s;

        if (i_func == FUNC_UE) begin
            o_v = ue_sat + 16'd1;
        end else if (s > 17'sd0) begin
            o_v = {s[14:0], 1'b0};
        end else begin
            o_v = {neg[14:0], 1'b1};
        end
    end

endmodule

FILE: design/egbw_pack.sv
// ----------------------------------------------------------------------------
// Exp-Golomb bit packer
// Shared shift unit that moves up to one byte of code bits per cycle into
// the pending byte (a full byte waits on tready) and drives the output register.
// ----------------------------------------------------------------------------
`include "exp_golomb_bit_writer_defines.svh"

module egbw_pack
    import egbw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pack_load i_load,
    output logic       o_busy,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,
    output logic       o_m_axis_tlast
);

    logic [31:0] r_val,   n_val;
    logic [5:0]  r_left,  n_left;
    logic        r_flush, n_flush;
    logic [7:0]  r_pend,  n_pend;
    logic [3:0]  r_cnt,   n_cnt;
    logic        r_ov,    n_ov;
    logic [7:0]  r_ob,    n_ob;
    logic        r_ol,    n_ol;

    logic       out_free;
    logic       emit;
    logic [3:0] free;
    logic [3:0] take;

    assign out_free = !r_ov || i_m_axis_tready;
    assign free     = 4'd8 - r_cnt;

    always_comb begin
        n_val   = r_val;
        n_left  = r_left;
        n_flush = r_flush;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_ob    = r_ob;
        n_ol    = r_ol;
        emit    = 1'b0;
        take    = 4'd0;
        if (i_load.valid) begin
            n_val   = i_load.val << (6'd32 - i_load.len);
            n_left  = i_load.len;
            n_flush = i_load.flush;
        end else if (r_left != 6'd0) begin
            if (r_cnt == 4'd8) begin
                if (out_free) begin
                    emit   = 1'b1;
                    n_ob   = r_pend;
                    n_ol   = (r_left <= 6'd8) && !r_flush;
                    take   = (r_left >= 6'd8) ? 4'd8 : r_left[3:0];
                    n_pend = r_val[31:24];
                    n_cnt  = take;
                    n_val  = r_val << take;
                    n_left = r_left - {2'b00, take};
                end
            end else begin
                take   = (r_left >= {2'b00, free}) ? free : r_left[3:0];
                n_pend = r_pend | (r_val[31:24] >> r_cnt);
                n_cnt  = r_cnt + take;
                n_val  = r_val << take;
                n_left = r_left - {2'b00, take};
            end
        end else if (r_flush) begin
            if (out_free) begin
                emit    = 1'b1;
                n_ob    = r_pend;
                n_ol    = 1'b1;
                n_pend  = 8'd0;
                n_cnt   = 4'd0;
                n_flush = 1'b0;
            end
        end
        n_ov = emit || (r_ov && !i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= 6'd0;
            r_flush <= 1'b0;
            r_pend  <= 8'd0;
            r_cnt   <= 4'd0;
            r_ov    <= 1'b0;
        end else begin
            r_left  <= n_left;
            r_flush <= n_flush;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_ob  <= n_ob;
        r_ol  <= n_ol;
    end

    assign o_busy          = (r_left != 6'd0) || r_flush;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_ob;
    assign o_m_axis_tlast  = r_ol;

    `EGBW_ASSERT_SAME(a_load_idle, i_clk, i_rst_n, i_load.valid, !o_busy,
        "Packer loaded while still busy.")
    `EGBW_ASSERT_SAME(a_flush_nonempty, i_clk, i_rst_n, r_flush && (r_left == 6'd0),
        r_cnt != 4'd0, "Flush reached with an empty pending byte.")
    `EGBW_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, emit,
        o_m_axis_tvalid, "Emitted word not presented on the output.")

endmodule

FILE: design/exp_golomb_bit_writer.sv
// ----------------------------------------------------------------------------
// Exp-Golomb bit writer
// Writes fixed fields, ue/se codes, scaling deltas and the RBSP stop bit
// into an MSB-first byte stream.
// ----------------------------------------------------------------------------
// Usage: one input word carries an operation in tuser and its operands in
// tdata. The output channel carries completed bytes; tlast marks the final
// byte caused by an input word. A full byte leaves only when a later bit
// needs room or the stop operation flushes it.
// Flow: an accepted word passes through code mapping and length sizing and
// is then packed step by step in the shared shifter, where a step fills the
// pending byte or emits it and starts the next one. A zero-width field loads
// no bits, an unused operation code skips the packer, and the input is not
// ready until the packer has drained its bits.
// Reset: the pending byte is cleared, no bits are held, the last scaling
// value is set to 8 and the output is empty.
// Stall: a byte waits in the output register while tready is low; the
// packer holds at the next emit and the input stays not ready.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer
    import egbw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] raw_bits, [37:32] field width, [54:38] coded_value,
    // [62:55] scale_value, [63] new_list
    input  logic [63:0] i_s_axis_tdata,
    // [2:0] func
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    t_state r_state, n_state;

    logic [2:0]         r_func;
    logic [31:0]        r_raw;
    logic [5:0]         r_cnt;
    logic signed [16:0] r_cv;
    logic [7:0]         r_sv;
    logic               r_nl;
    logic [7:0]         r_prev_scale;
    logic [15:0]        r_v;

    logic       accept;
    logic       busy;
    logic [15:0] code_v;
    logic [4:0] msb_len;
    t_pack_load load;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    egbw_code u_code (
        .i_func        (r_func),
        .i_coded_value (r_cv),
        .i_scale_value (r_sv),
        .i_new_list    (r_nl),
        .i_prev_scale  (r_prev_scale),
        .o_v           (code_v)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_state = S_SIZE;
            end
            S_SIZE: begin
                n_state = (r_func <= FUNC_STOP) ? S_RUN : S_IDLE;
            end
            S_RUN: begin
                if (!busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign msb_len = f_msb_len(r_v);

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        load.valid = 1'b0;
        load.val   = 32'd0;
        load.len   = 6'd0;
        load.flush = 1'b0;
        if (r_state == S_SIZE) begin
            case (r_func)
                FUNC_FIXED: begin
                    load.valid = 1'b1;
                    load.val   = r_raw;
                    load.len   = (r_cnt > MAX_FIXED_BITS) ? MAX_FIXED_BITS : r_cnt;
                end
                FUNC_UE, FUNC_SE, FUNC_SCALE: begin
                    load.valid = 1'b1;
                    load.val   = {16'd0, r_v};
                    load.len   = {msb_len, 1'b0} - 6'd1;
                end
                FUNC_STOP: begin
                    load.valid = 1'b1;
                    load.val   = 32'd1;
                    load.len   = 6'd1;
                    load.flush = 1'b1;
                end
                default: begin
                    load.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_scale <= SCALE_RESET;
        end else begin
            r_state <= n_state;
            if ((r_state == S_MAP) && (r_func == FUNC_SCALE)) begin
                r_prev_scale <= r_sv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_s_axis_tuser;
            r_raw  <= i_s_axis_tdata[31:0];
            r_cnt  <= i_s_axis_tdata[37:32];
            r_cv   <= signed'(i_s_axis_tdata[54:38]);
            r_sv   <= i_s_axis_tdata[62:55];
            r_nl   <= i_s_axis_tdata[63];
        end
        if (r_state == S_MAP) begin
            r_v <= code_v;
        end
    end

    egbw_pack u_pack (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .o_busy          (busy),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
